// File: design/bknl_pkg.sv
`timescale 1ns / 1ps
// Package for the bounded k-nearest candidate list.
// Holds widths, defaults and the cell control struct; no dependencies.
package bknl_pkg;

  // Width of the active_k register and of the fill count
  localparam int K_BITS   = 5;
  localparam int CNT_BITS = 5;

  // Defaults for the top-level parameters
  localparam int DEF_LIST_DEPTH = 16;
  localparam int DEF_INDEX_BITS = 24;
  localparam int DEF_DIST_BITS  = 32;

  // Value of active_k after reset
  localparam logic [K_BITS-1:0] K_RESET = K_BITS'(16);

  // Broadcast control for one list cell
  typedef struct packed {
    logic step;      // a request is taken this cycle
    logic in_range;  // slot lies below the kept count
    logic occupied;  // slot holds a live entry
  } cell_ctrl_t;

endpackage

// File: design/bknl_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the bounded k-nearest list: candidate, result, config.
// Depends on bknl_pkg for the fixed count and register widths.

interface bknl_cand_if #(
  parameter int DIST_BITS  = bknl_pkg::DEF_DIST_BITS,
  parameter int INDEX_BITS = bknl_pkg::DEF_INDEX_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  restart;
  logic [DIST_BITS-1:0]  cand_dist;
  logic [INDEX_BITS-1:0] cand_index;

  modport source (output valid, restart, cand_dist, cand_index, input ready);
  modport sink   (input valid, restart, cand_dist, cand_index, output ready);
endinterface

interface bknl_result_if #(
  parameter int DIST_BITS  = bknl_pkg::DEF_DIST_BITS,
  parameter int INDEX_BITS = bknl_pkg::DEF_INDEX_BITS
);
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic                           evicted_valid;
  logic [INDEX_BITS-1:0]          evicted_index;
  logic [bknl_pkg::CNT_BITS-1:0]  fill_count;
  logic [DIST_BITS-1:0]           worst_dist;

  modport source (output valid, accepted, evicted_valid, evicted_index, fill_count,
                  worst_dist, input ready);
  modport sink   (input valid, accepted, evicted_valid, evicted_index, fill_count,
                  worst_dist, output ready);
endinterface

interface bknl_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bknl_pkg::K_BITS-1:0]  active_k;

  modport source (output valid, active_k, input ready);
  modport sink   (input valid, active_k, output ready);
endinterface

// File: design/bknl_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted candidate list: compare against the candidate and
// take either the candidate or the left neighbor's entry. Depends on bknl_pkg.
module bknl_cell #(
  parameter int DIST_BITS  = bknl_pkg::DEF_DIST_BITS,
  parameter int INDEX_BITS = bknl_pkg::DEF_INDEX_BITS
) (
  input  logic                    clk,
  input  bknl_pkg::cell_ctrl_t    ctrl,
  input  logic [DIST_BITS-1:0]    cand_dist,
  input  logic [INDEX_BITS-1:0]   cand_index,
  input  logic                    prev_beyond,
  input  logic [DIST_BITS-1:0]    prev_dist,
  input  logic [INDEX_BITS-1:0]   prev_index,
  output logic                    beyond,
  output logic [DIST_BITS-1:0]    slot_dist,
  output logic [INDEX_BITS-1:0]   index,
  output logic [DIST_BITS-1:0]    dist_next
);

  logic [INDEX_BITS-1:0] index_next;

  // Candidate lands at or left of this slot when the slot is empty or worse
  assign beyond = !ctrl.occupied || (slot_dist > cand_dist);

  // Insert at the boundary, shift right past it, hold otherwise
  always_comb begin
    dist_next  = slot_dist;
    index_next = index;
    if (ctrl.in_range) begin
      if (prev_beyond) begin
        dist_next  = prev_dist;
        index_next = prev_index;
      end else if (beyond) begin
        dist_next  = cand_dist;
        index_next = cand_index;
      end
    end
  end

  // Update the slot on each taken request
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      slot_dist <= dist_next;
      index     <= index_next;
    end
  end

endmodule

// File: design/bounded_k_nearest_list.sv
`timescale 1ns / 1ps
// Top level of the bounded k-nearest candidate list: a row of bknl_cell slots,
// fill count, active_k register and a two-entry result buffer.
// Depends on bknl_pkg, bknl_if and bknl_cell.
//
//   channel  dir  handshake      payload
//   cand     in   valid/ready    restart, cand_dist, cand_index
//   result   out  valid/ready    accepted, evicted_valid, evicted_index,
//                                fill_count, worst_dist
//   cfg      in   valid/ready    active_k (ready always high)
//
// One candidate per cycle while cand.ready is high: all slots compare and shift
// in parallel when the request is taken, and the result is registered with them.
// The per-cycle path is one distance compare per cell plus a slot select by k.
// Reset (rst, synchronous) empties the list and sets active_k to 16.
// A stalled result sink is absorbed by a skid entry; cand.ready drops only
// when both result entries are full.
module bounded_k_nearest_list #(
  parameter int LIST_DEPTH = bknl_pkg::DEF_LIST_DEPTH,
  parameter int INDEX_BITS = bknl_pkg::DEF_INDEX_BITS,
  parameter int DIST_BITS  = bknl_pkg::DEF_DIST_BITS
) (
  input logic                  clk,
  input logic                  rst,
  bknl_cand_if.sink            cand,
  bknl_result_if.source        result,
  bknl_cfg_if.sink             cfg
);

  localparam int CW    = bknl_pkg::CNT_BITS;
  localparam int SEL_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  // Configuration and list control
  logic [bknl_pkg::K_BITS-1:0] active_k;
  logic [CW-1:0]               fill_level;
  logic [CW-1:0]               cap;
  logic [CW-1:0]               cap_m1;
  logic [SEL_W-1:0]            sel;
  logic [CW-1:0]               cnt_now;
  logic [CW-1:0]               cnt_next;
  logic                        full;
  logic                        step;

  // Cell row
  bknl_pkg::cell_ctrl_t        ctrl   [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]       beyond;
  logic [LIST_DEPTH-1:0]       prev_beyond;
  logic [DIST_BITS-1:0]        slot_dist [LIST_DEPTH];
  logic [INDEX_BITS-1:0]       index  [LIST_DEPTH];
  logic [DIST_BITS-1:0]        dist_next [LIST_DEPTH];
  logic [DIST_BITS-1:0]        prev_dist  [LIST_DEPTH];
  logic [INDEX_BITS-1:0]       prev_index [LIST_DEPTH];

  // New result fields
  logic                        acc;
  logic                        ev_valid;
  logic [INDEX_BITS-1:0]       ev_index;
  logic [DIST_BITS-1:0]        worst_next;

  // Result buffer: output entry and skid entry
  logic                        o_valid;
  logic                        o_acc;
  logic                        o_ev;
  logic [INDEX_BITS-1:0]       o_ev_index;
  logic [CW-1:0]               o_fill;
  logic [DIST_BITS-1:0]        o_worst;
  logic                        s_valid;
  logic                        s_acc;
  logic                        s_ev;
  logic [INDEX_BITS-1:0]       s_ev_index;
  logic [CW-1:0]               s_fill;
  logic [DIST_BITS-1:0]        s_worst;
  logic                        o_free;
  logic                        o_valid_next;
  logic                        s_valid_next;

  assign step      = cand.valid && cand.ready;
  assign cand.ready = !s_valid;
  assign cfg.ready  = 1'b1;

  // Clamp active_k into 1..LIST_DEPTH
  always_comb begin
    if (active_k == '0) begin
      cap = CW'(1);
    end else if (32'(active_k) > 32'(LIST_DEPTH)) begin
      cap = CW'(LIST_DEPTH);
    end else begin
      cap = CW'(active_k);
    end
  end
  assign cap_m1 = cap - CW'(1);
  assign sel    = SEL_W'(cap_m1);

  // Live entry count, emptied first on restart
  always_comb begin
    if (cand.restart) begin
      cnt_now = '0;
    end else if (fill_level > cap) begin
      cnt_now = cap;
    end else begin
      cnt_now = fill_level;
    end
  end
  assign full = (cnt_now == cap);

  // Build the cell row
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    assign ctrl[i].step     = step;
    assign ctrl[i].in_range = (32'(i) < 32'(cap));
    assign ctrl[i].occupied = (32'(i) < 32'(cnt_now));

    if (i == 0) begin : g_head
      assign prev_beyond[i] = 1'b0;
      assign prev_dist[i]   = '0;
      assign prev_index[i]  = '0;
    end else begin : g_link
      assign prev_beyond[i] = beyond[i-1];
      assign prev_dist[i]   = slot_dist[i-1];
      assign prev_index[i]  = index[i-1];
    end

    bknl_cell #(
      .DIST_BITS  (DIST_BITS),
      .INDEX_BITS (INDEX_BITS)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl[i]),
      .cand_dist   (cand.cand_dist),
      .cand_index  (cand.cand_index),
      .prev_beyond (prev_beyond[i]),
      .prev_dist   (prev_dist[i]),
      .prev_index  (prev_index[i]),
      .beyond      (beyond[i]),
      .slot_dist   (slot_dist[i]),
      .index       (index[i]),
      .dist_next   (dist_next[i])
    );
  end

  // Candidate is kept when it lands at or left of the last kept slot
  assign acc      = beyond[sel];
  assign ev_valid = acc && full;
  assign ev_index = ev_valid ? index[sel] : '0;
  assign cnt_next = cnt_now + CW'(acc && !full);
  assign worst_next = (cnt_next == cap) ? dist_next[sel] : {DIST_BITS{1'b1}};

  // Hold the fill count and the active_k register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_level <= '0;
      active_k   <= bknl_pkg::K_RESET;
    end else begin
      if (step) begin
        fill_level <= cnt_next;
      end
      if (cfg.valid && cfg.ready) begin
        active_k <= cfg.active_k;
      end
    end
  end

  // Result buffer control: refill output from skid first, then from the list
  assign o_free = !o_valid || result.ready;

  always_comb begin
    o_valid_next = o_valid;
    s_valid_next = s_valid;
    if (o_free) begin
      o_valid_next = s_valid || step;
      s_valid_next = s_valid && step;
    end else if (step) begin
      s_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else begin
      o_valid <= o_valid_next;
      s_valid <= s_valid_next;
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    if (o_free) begin
      if (s_valid) begin
        o_acc      <= s_acc;
        o_ev       <= s_ev;
        o_ev_index <= s_ev_index;
        o_fill     <= s_fill;
        o_worst    <= s_worst;
      end else if (step) begin
        o_acc      <= acc;
        o_ev       <= ev_valid;
        o_ev_index <= ev_index;
        o_fill     <= cnt_next;
        o_worst    <= worst_next;
      end
    end
    if (step && (s_valid || !o_free)) begin
      s_acc      <= acc;
      s_ev       <= ev_valid;
      s_ev_index <= ev_index;
      s_fill     <= cnt_next;
      s_worst    <= worst_next;
    end
  end

  assign result.valid         = o_valid;
  assign result.accepted      = o_acc;
  assign result.evicted_valid = o_ev;
  assign result.evicted_index = o_ev_index;
  assign result.fill_count    = o_fill;
  assign result.worst_dist    = o_worst;

`ifndef NO_ASSERTIONS
  // Skid entry is only used behind a full output entry
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> o_valid)
    else $error("skid entry holds a result while output entry is empty");

  // An eviction comes only with an accepted candidate
  a_evict_needs_accept: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_ev |-> o_acc)
    else $error("eviction reported for a rejected candidate");

  // Evicting keeps the count; growing the count never evicts
  a_evict_keeps_count: assert property (@(posedge clk) disable iff (rst)
    step && ev_valid |=> fill_level == $past(cnt_now))
    else $error("fill count changed on an eviction");

  // Kept entries stay sorted: the insertion boundary is a single step
  for (genvar j = 1; j < LIST_DEPTH; j++) begin : g_chk_sorted
    a_boundary_monotone: assert property (@(posedge clk) disable iff (rst)
      beyond[j-1] |-> beyond[j])
      else $error("candidate list lost its ascending order");
  end
`endif

endmodule

// File: bench/bknl_list_checker.sv
`timescale 1ns / 1ps
// Checker for the bounded k-nearest list: watches the candidate, result and
// config channels, predicts every result and compares it field by field.
// Depends on bknl_pkg and the channel interfaces in bknl_if.
module bknl_list_checker #(
  parameter int LIST_DEPTH = bknl_pkg::DEF_LIST_DEPTH,
  parameter int INDEX_BITS = bknl_pkg::DEF_INDEX_BITS,
  parameter int DIST_BITS  = bknl_pkg::DEF_DIST_BITS
) (
  input  logic   clk,
  input  logic   rst,
  bknl_cand_if   cand,
  bknl_result_if result,
  bknl_cfg_if    cfg,
  output int     fail_count,
  output int     outstanding,
  output int     results_seen,
  output int     accept_count,
  output int     evict_count
);

  typedef struct packed {
    logic                          accepted;
    logic                          evicted_valid;
    logic [INDEX_BITS-1:0]         evicted_index;
    logic [bknl_pkg::CNT_BITS-1:0] fill_count;
    logic [DIST_BITS-1:0]          worst_dist;
  } outcome_t;

  localparam logic [DIST_BITS-1:0] DIST_INF = '1;

  // Shadow copy of the list, fill level and active_k
  logic [DIST_BITS-1:0]        dist_slot  [LIST_DEPTH];
  logic [INDEX_BITS-1:0]       index_slot [LIST_DEPTH];
  int                          fill_level;
  logic [bknl_pkg::K_BITS-1:0] k_reg;
  outcome_t                    outcome_q [$];

  // Offer one candidate to the shadow list and work out the result it causes
  task automatic place_candidate(input logic restart, input logic [DIST_BITS-1:0] d,
                                 input logic [INDEX_BITS-1:0] idx, output outcome_t o);
    int                    cap;
    int                    cnt;
    int                    pos;
    int                    s;
    logic                  full;
    logic [DIST_BITS-1:0]  worst;
    logic [INDEX_BITS-1:0] old_last;
    o = '0;
    cap = (k_reg == 0) ? 1 : (int'(k_reg) > LIST_DEPTH) ? LIST_DEPTH : int'(k_reg);
    if (restart) begin
      foreach (dist_slot[i]) dist_slot[i] = DIST_INF;
      fill_level = 0;
    end
    cnt = (fill_level > cap) ? cap : fill_level;
    full = (cnt == cap);
    worst = full ? dist_slot[cap-1] : DIST_INF;
    if (d <= worst) begin
      old_last = full ? index_slot[cap-1] : '0;
      // Ties stay ahead of the newcomer
      pos = cnt;
      while (pos > 0 && dist_slot[pos-1] > d) pos--;
      if (pos < cap) begin
        s = (cnt < cap) ? cnt : cap - 1;
        while (s > pos) begin
          dist_slot[s]  = dist_slot[s-1];
          index_slot[s] = index_slot[s-1];
          s--;
        end
        dist_slot[pos]  = d;
        index_slot[pos] = idx;
        o.accepted = 1'b1;
        if (full) begin
          o.evicted_valid = 1'b1;
          o.evicted_index = old_last;
        end else begin
          cnt++;
        end
      end
    end
    fill_level = cnt;
    o.fill_count = bknl_pkg::CNT_BITS'(cnt);
    o.worst_dist = (cnt == cap) ? dist_slot[cap-1] : DIST_INF;
  endtask

  // Print one mismatch line and count it
  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("mismatch at result %0d: %s expected 0x%0h got 0x%0h",
             results_seen, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    outcome_t want;
    outcome_t fresh;
    if (rst) begin
      foreach (dist_slot[i]) dist_slot[i] = DIST_INF;
      foreach (index_slot[i]) index_slot[i] = '0;
      fill_level = 0;
      k_reg = bknl_pkg::K_RESET;
      outcome_q.delete();
      fail_count   = 0;
      results_seen = 0;
      accept_count = 0;
      evict_count  = 0;
    end else begin
      // Compare a delivered result against the oldest prediction
      if (result.valid && result.ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, 64'd1);
        end else begin
          want = outcome_q.pop_front();
          if (result.accepted !== want.accepted)
            report_mismatch("accepted", 64'(want.accepted), 64'(result.accepted));
          if (result.evicted_valid !== want.evicted_valid)
            report_mismatch("evicted_valid", 64'(want.evicted_valid),
                            64'(result.evicted_valid));
          if (result.evicted_index !== want.evicted_index)
            report_mismatch("evicted_index", 64'(want.evicted_index),
                            64'(result.evicted_index));
          if (result.fill_count !== want.fill_count)
            report_mismatch("fill_count", 64'(want.fill_count), 64'(result.fill_count));
          if (result.worst_dist !== want.worst_dist)
            report_mismatch("worst_dist", 64'(want.worst_dist), 64'(result.worst_dist));
          accept_count += int'(want.accepted);
          evict_count  += int'(want.evicted_valid);
        end
        results_seen++;
      end
      // Predict the result of an accepted request
      if (cand.valid && cand.ready) begin
        place_candidate(cand.restart, cand.cand_dist, cand.cand_index, fresh);
        outcome_q = {outcome_q, fresh};
      end
      // Register write takes effect after this edge's request
      if (cfg.valid && cfg.ready) k_reg = cfg.active_k;
    end
    outstanding = outcome_q.size();
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Testbench top for bounded_k_nearest_list: drives candidates, config writes
// and result stalls, and gives the verdict. Depends on bknl_pkg, bknl_if, the
// bounded_k_nearest_list module and the bknl_list_checker module.
module tb;

  localparam int INDEX_BITS  = bknl_pkg::DEF_INDEX_BITS;
  localparam int DIST_BITS   = bknl_pkg::DEF_DIST_BITS;
  localparam int K_BITS      = bknl_pkg::K_BITS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 123;

  localparam logic [DIST_BITS-1:0]  DIST_INF  = '1;
  localparam logic [INDEX_BITS-1:0] INDEX_TOP = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic idle_on = 1'b1;
  int   cycle_count = 0;
  int   items_sent = 0;
  int   fail_count;
  int   outstanding;
  int   results_seen;
  int   accept_count;
  int   evict_count;

  bknl_cand_if   cand_ch ();
  bknl_result_if result_ch ();
  bknl_cfg_if    cfg_ch ();

  bounded_k_nearest_list u_dut (
    .clk    (clk),
    .rst    (rst),
    .cand   (cand_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  bknl_list_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cand         (cand_ch),
    .result       (result_ch),
    .cfg          (cfg_ch),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .results_seen (results_seen),
    .accept_count (accept_count),
    .evict_count  (evict_count)
  );

  always #4 clk = ~clk;

  // End the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Stall the result sink in random bursts while idle_on is set
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Offer one candidate request, with an optional gap ahead of it
  task automatic send_candidate(input logic restart, input logic [DIST_BITS-1:0] d,
                                input logic [INDEX_BITS-1:0] idx);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cand_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    cand_ch.valid      <= 1'b1;
    cand_ch.restart    <= restart;
    cand_ch.cand_dist  <= d;
    cand_ch.cand_index <= idx;
    do @(posedge clk); while (!cand_ch.ready);
    items_sent++;
  endtask

  // Hold until every predicted result has been delivered
  task automatic wait_drained();
    cand_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Write active_k while the list is idle
  task automatic write_k(input logic [K_BITS-1:0] k);
    wait_drained();
    cfg_ch.valid    <= 1'b1;
    cfg_ch.active_k <= k;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [K_BITS-1:0]    k_plan [NUM_PHASES];
    logic [DIST_BITS-1:0] d;
    logic                 restart;
    logic                 broken;
    int                   items_left;
    int                   run_len;
    int                   band;

    cand_ch.valid      <= 1'b0;
    cand_ch.restart    <= 1'b0;
    cand_ch.cand_dist  <= '0;
    cand_ch.cand_index <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.active_k    <= bknl_pkg::K_RESET;

    // Hold reset, then release it
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: two requests at the reset value of active_k
    send_candidate(1'b1, 32'd7, '0);
    send_candidate(1'b0, 32'd3, INDEX_TOP);

    // Directed: ties, eviction, infinite distances and restarts at k = 3
    write_k(K_BITS'(3));
    send_candidate(1'b1, 32'd100, 24'd1);
    send_candidate(1'b0, 32'd50, 24'd2);
    send_candidate(1'b0, 32'd100, 24'd3);     // tie lands after the equal entry
    send_candidate(1'b0, 32'd100, 24'd4);     // tie with worst on a full list
    send_candidate(1'b0, '0, INDEX_TOP);      // best possible, evicts the last
    send_candidate(1'b0, DIST_INF, 24'd5);    // infinite against a finite worst
    send_candidate(1'b0, 32'd101, 24'd6);
    send_candidate(1'b0, 32'd99, 24'd7);
    send_candidate(1'b1, DIST_INF, 24'd8);    // infinite into an empty list
    send_candidate(1'b0, DIST_INF, 24'd9);
    send_candidate(1'b0, DIST_INF, 24'd10);
    send_candidate(1'b0, DIST_INF, 24'd11);   // full of infinities: rejected
    send_candidate(1'b0, DIST_INF - 1, '0);
    send_candidate(1'b1, '0, '0);             // restart on a full list
    send_candidate(1'b0, '0, 24'hAAAAAA);
    send_candidate(1'b0, '0, 24'h555555);
    send_candidate(1'b0, 32'hAAAAAAAA, 24'd12);
    send_candidate(1'b0, 32'h55555555, 24'd13);

    // Random phases; the first request of each may continue the old query
    k_plan = '{K_BITS'(1), K_BITS'(0), K_BITS'(31), K_BITS'(2), K_BITS'(17),
               K_BITS'(16), K_BITS'(7), K_BITS'(4), K_BITS'(0), K_BITS'(0),
               K_BITS'(0), K_BITS'(16)};
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p >= 8 && p <= 10) k_plan[p] = K_BITS'($urandom_range(0, 31));
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      write_k(k_plan[p]);
      items_left = PHASE_ITEMS;
      while (items_left > 0) begin
        // Mostly queries that start with a restart; some start without one
        run_len = $urandom_range(1, 40);
        broken  = ($urandom_range(0, 9) == 0);
        band    = $urandom_range(0, 3);
        for (int j = 0; j < run_len && items_left > 0; j++) begin
          restart = (j == 0 && !broken) || ($urandom_range(0, 29) == 0);
          case (band)
            0: d = DIST_BITS'($urandom_range(0, 15));
            1: d = DIST_BITS'($urandom_range(0, 1023));
            2: d = DIST_BITS'($urandom);
            default: begin
              case ($urandom_range(0, 3))
                0: d = '0;
                1: d = DIST_INF;
                2: d = DIST_INF - 1;
                default: d = DIST_BITS'($urandom_range(0, 8));
              endcase
            end
          endcase
          send_candidate(restart, d, INDEX_BITS'($urandom));
          items_left--;
        end
      end
    end

    // Drain and let the pipeline settle
    wait_drained();
    repeat (10) @(posedge clk);

    $display("sent %0d candidates over %0d active_k settings", items_sent, NUM_PHASES + 2);
    $display("checked %0d results: %0d accepted, %0d evictions",
             results_seen, accept_count, evict_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
design/bknl_pkg.sv
design/bknl_if.sv
design/bknl_cell.sv
design/bounded_k_nearest_list.sv
bench/bknl_list_checker.sv
bench/tb.sv
